### rtl/sha512_pkg.sv
// Package: payload types, round constants and initial hash values for the SHA-512/384 engine.
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_result;
    } out_word_t;

    localparam int NUM_ROUNDS = 80;
    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    localparam logic [63:0] ROUND_K [0:79] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] IV_512 [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] IV_384 [0:7] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        rotr64 = (x >> n) | (x << (64 - n));
    endfunction

endpackage

### rtl/sha512_round.sv
// One SHA-512 round with in-place schedule update; shared by all 80 rounds of a block.
module sha512_round (
    input  logic [63:0] wv_in [0:7],
    input  logic [63:0] win   [0:15],
    input  logic [6:0]  round,
    output logic [63:0] wv_out [0:7],
    output logic [63:0] w_new
);
    import sha512_pkg::*;

    logic [3:0]  t0;
    logic [3:0]  t2;
    logic [3:0]  t7;
    logic [3:0]  t15;
    logic [63:0] w2;
    logic [63:0] w15;
    logic [63:0] w;
    logic [63:0] t1;
    logic [63:0] tt2;
    logic [63:0] a, b, c, e, f, g;

    always_comb
    begin
        t0  = round[3:0];
        t2  = round[3:0] - 4'd2;
        t7  = round[3:0] - 4'd7;
        t15 = round[3:0] - 4'd15;
        w2  = win[t2];
        w15 = win[t15];
        if (round < 7'd16)
        begin
            w = win[t0];
        end
        else
        begin
            w = (rotr64(w2, 19) ^ rotr64(w2, 61) ^ (w2 >> 6)) + win[t7]
              + (rotr64(w15, 1) ^ rotr64(w15, 8) ^ (w15 >> 7)) + win[t0];
        end
        w_new = w;
        a = wv_in[0]; b = wv_in[1]; c = wv_in[2];
        e = wv_in[4]; f = wv_in[5]; g = wv_in[6];
        t1 = wv_in[7] + (rotr64(e, 14) ^ rotr64(e, 18) ^ rotr64(e, 41))
           + ((e & f) ^ (~e & g)) + ROUND_K[round] + w;
        tt2 = (rotr64(a, 28) ^ rotr64(a, 34) ^ rotr64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
        wv_out[7] = g;
        wv_out[6] = f;
        wv_out[5] = e;
        wv_out[4] = wv_in[3] + t1;
        wv_out[3] = c;
        wv_out[2] = b;
        wv_out[1] = a;
        wv_out[0] = t1 + tt2;
    end

endmodule

### rtl/sha512_384_hash_engine.sv
// SHA-512/384 engine: one input word per cycle until a block fills, then 80 rounds.
// A non-final word that completes a block stalls the input through the accept, the
// 80 rounds and the add; other non-final words do not stall. A last word pads (zero
// fill one word per cycle, then the rounds and add for each padded block, one or
// two blocks), then emits 8 or 6 digest words, one per cycle while not stalled.
// Throughput is set by the single shared round unit: no new words are taken while a
// block is compressed. rst_n clears control state asynchronously and selects SHA-512 with its initial hash values.
module sha512_384_hash_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  sha512_pkg::in_word_t   in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output sha512_pkg::out_word_t  out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg;
    logic        variant_reg;
    logic        act_var_reg;
    logic        busy_reg;
    logic [63:0] hash_reg [0:7];
    logic [63:0] wv_reg   [0:7];
    logic [63:0] win_reg  [0:15];
    logic [3:0]  wib_reg;
    logic [63:0] bits_reg;
    logic [6:0]  round_reg;
    logic        final_reg;   // padding sequence in progress
    logic        pad_owed_reg; // the 0x80 word is still owed
    logic        len_ok_reg;   // current block has room for the length word
    logic [2:0]  oidx_reg;
    // set once the length word is pushed; the next compression is the last
    logic        done_pad_reg;

    logic [63:0] wv_nx [0:7];
    logic [63:0] w_new;
    logic        accept;
    logic [3:0]  vb;
    logic [63:0] bits_next;
    logic [63:0] kept;
    logic [63:0] padded;
    logic [63:0] push_word;
    logic [2:0]  last_idx;

    sha512_round u_round (
        .wv_in  (wv_reg),
        .win    (win_reg),
        .round  (round_reg),
        .wv_out (wv_nx),
        .w_new  (w_new)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign last_idx  = act_var_reg ? 3'd5 : 3'd7;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.digest_word  = hash_reg[oidx_reg];
    assign out_data.digest_index = oidx_reg;
    assign out_data.last_result  = (oidx_reg == last_idx);

    always_comb
    begin
        vb = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
        kept = (vb == 4'd0) ? 64'd0 : (in_data.data_word & (~64'd0 << (7'd64 - {vb, 3'd0})));
        padded = kept | (PAD_WORD >> {vb, 3'd0});
        bits_next = (busy_reg ? bits_reg : 64'd0)
                  + (in_data.last_word ? {57'd0, vb, 3'd0} : 64'd64);
        push_word = (in_data.last_word && vb != 4'd8) ? padded : in_data.data_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            variant_reg  <= 1'b0;
            act_var_reg  <= 1'b0;
            busy_reg     <= 1'b0;
            wib_reg      <= 4'd0;
            bits_reg     <= 64'd0;
            round_reg    <= 7'd0;
            final_reg    <= 1'b0;
            pad_owed_reg <= 1'b0;
            len_ok_reg   <= 1'b0;
            oidx_reg     <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= IV_512[i];
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                variant_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        busy_reg <= 1'b1;
                        if (!busy_reg)
                        begin
                            act_var_reg <= variant_reg;
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= variant_reg ? IV_384[i] : IV_512[i];
                                wv_reg[i]   <= variant_reg ? IV_384[i] : IV_512[i];
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                wv_reg[i] <= hash_reg[i];
                            end
                        end
                        bits_reg <= bits_next;
                        win_reg[wib_reg] <= push_word;
                        wib_reg <= wib_reg + 4'd1;
                        round_reg <= 7'd0;
                        if (in_data.last_word)
                        begin
                            final_reg <= 1'b1;
                            // full last word: the 0x80 byte goes in the next slot
                            pad_owed_reg <= (vb == 4'd8);
                            len_ok_reg   <= (wib_reg <= 4'd13);
                            if (wib_reg == 4'd15)
                            begin
                                state_reg <= ST_ROUND;
                            end
                            else
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else if (wib_reg == 4'd15)
                        begin
                            state_reg <= ST_ROUND;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (pad_owed_reg)
                    begin
                        win_reg[wib_reg] <= PAD_WORD;
                        pad_owed_reg <= 1'b0;
                        len_ok_reg   <= (wib_reg <= 4'd13);
                    end
                    else if (wib_reg == 4'd15 && len_ok_reg)
                    begin
                        win_reg[wib_reg] <= bits_reg;
                    end
                    else
                    begin
                        win_reg[wib_reg] <= 64'd0;
                    end
                    wib_reg <= wib_reg + 4'd1;
                    round_reg <= 7'd0;
                    for (int i = 0; i < 8; i++)
                    begin
                        wv_reg[i] <= hash_reg[i];
                    end
                    if (wib_reg == 4'd15)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        wv_reg[i] <= wv_nx[i];
                    end
                    win_reg[round_reg[3:0]] <= w_new;
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == 7'(NUM_ROUNDS - 1))
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + wv_reg[i];
                    end
                    round_reg <= 7'd0;
                    if (!final_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (done_pad_reg)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        // length did not fit: one more block of padding
                        state_reg  <= ST_PAD;
                        len_ok_reg <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (oidx_reg == last_idx)
                        begin
                            oidx_reg  <= 3'd0;
                            state_reg <= ST_IDLE;
                            busy_reg  <= 1'b0;
                            final_reg <= 1'b0;
                            wib_reg   <= 4'd0;
                            bits_reg  <= 64'd0;
                        end
                        else
                        begin
                            oidx_reg <= oidx_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_pad_reg <= 1'b0;
        end
        else if (state_reg == ST_PAD && !pad_owed_reg && len_ok_reg && wib_reg == 4'd15)
        begin
            done_pad_reg <= 1'b1;
        end
        else if (state_reg == ST_ADD)
        begin
            done_pad_reg <= 1'b0;
        end
    end

endmodule
